[hdl/rsi_pkg.sv]
// rsi_pkg: shared widths and the per-item status flags of the ray/sphere test
// no dependencies; used by the channel interfaces and the top level
package rsi_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;

  typedef struct packed {
    logic azero;  // direction vector is zero
    logic dneg;   // discriminant below zero
    logic dzero;  // discriminant exactly zero
  } flags_t;

endpackage

[hdl/rsi_ifs.sv]
// rsi_ifs: valid/ready channels of the ray/sphere test (ray in, result out, config)
// depends on rsi_pkg for the field widths
interface rsi_ray_if;
  logic valid;
  logic ready;
  logic signed [rsi_pkg::COORD_W-1:0] origin_x;
  logic signed [rsi_pkg::COORD_W-1:0] origin_y;
  logic signed [rsi_pkg::COORD_W-1:0] origin_z;
  logic signed [rsi_pkg::COORD_W-1:0] dir_x;
  logic signed [rsi_pkg::COORD_W-1:0] dir_y;
  logic signed [rsi_pkg::COORD_W-1:0] dir_z;
  logic signed [rsi_pkg::COORD_W-1:0] center_x;
  logic signed [rsi_pkg::COORD_W-1:0] center_y;
  logic signed [rsi_pkg::COORD_W-1:0] center_z;
  logic [rsi_pkg::RAD_W-1:0] radius;

  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 center_x, center_y, center_z, radius, input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, radius, output ready);
endinterface

interface rsi_hit_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [rsi_pkg::COORD_W-1:0] hit_distance;
  logic tangent;

  modport source(output valid, hit, hit_distance, tangent, input ready);
  modport sink(input valid, hit, hit_distance, tangent, output ready);
endinterface

interface rsi_cfg_if;
  logic valid;
  logic ready;
  logic [rsi_pkg::RAD_W-1:0] min_hit_distance;

  modport source(output valid, min_hit_distance, input ready);
  modport sink(input valid, min_hit_distance, output ready);
endinterface

[hdl/rsi_mul.sv]
// rsi_mul: wide unsigned multiplier built from 32x32 partial products
// stages: partial products, row sums, final sum; no package dependency
module rsi_mul #(
  parameter int WA = 67,
  parameter int WB = 67
) (
  input  logic               clk,
  input  logic               en,
  input  logic [WA-1:0]      a,
  input  logic [WB-1:0]      b,
  output logic [WA+WB-1:0]   p
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int WR = 32 * NB + 32;
  localparam int WP = WA + WB;

  logic [32*NA-1:0] a_ext;
  logic [32*NB-1:0] b_ext;
  logic [63:0]      pp [NA][NB];
  logic [WR-1:0]    row [NA];
  logic [WR-1:0]    row_next [NA];
  logic [WP-1:0]    p_next;

  assign a_ext = (32*NA)'(a);
  assign b_ext = (32*NB)'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (WR'(pp[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    p_next = '0;
    for (int i = 0; i < NA; i++) begin
      p_next = p_next + (WP'(row[i]) << (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
        end
        row[i] <= row_next[i];
      end
      p <= p_next;
    end
  end

endmodule

[hdl/ray_sphere_intersect.sv]
// ray_sphere_intersect: pipelined ray/sphere hit test in signed fixed point
// depends on rsi_pkg, rsi_ifs (channel interfaces) and rsi_mul
//
// Channels: ray (sink) takes origin, direction, sphere center and radius;
// result (source) gives hit, hit_distance and tangent; cfg (sink) writes the
// minimum hit distance and is always ready. Each is valid/ready: an item moves
// on a rising edge with valid and ready both high.
// Pipeline: 68 stages of the digit-by-digit square root, 32 stages of the
// restoring divider, plus products, the 3-stage wide multiplier and setup stages.
// Throughput: one ray per cycle unless stalled; every stage carries its own valid bit.
// Stall: when a result is held and result.ready is low the whole pipeline
// freezes and ray.ready drops; nothing is lost or repeated.
// Reset: clears all valid bits and sets the minimum hit distance to 1.0.
// The minimum hit distance is sampled at the last stage, so write it only when
// no item is in flight.
module ray_sphere_intersect #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  rsi_ray_if.sink   ray,
  rsi_hit_if.source result,
  rsi_cfg_if.sink   cfg
);

  localparam int WDV = 33;            // origin - center
  localparam int WH  = 67;            // h = D.d, signed
  localparam int WA  = 64;            // A = D.D
  localparam int WC  = 67;            // C = d.d - r^2, signed
  localparam int WS  = 136;           // discriminant
  localparam int NSQ = 68;            // root bits
  localparam int WN  = 70;            // h + root, signed
  localparam int WM  = WN + 1 + FRAC_BITS;
  localparam int WD  = (WM > 97) ? WM : 97;
  localparam int NDV = 32;            // quotient bits
  localparam int L   = 4 + 3 + 1 + NSQ + 4 + NDV + 1;

  logic         adv;
  logic [L-1:0] vld;
  logic [rsi_pkg::RAD_W-1:0] min_dist;

  assign adv       = !vld[L-1] || result.ready;
  assign ray.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      min_dist <= rsi_pkg::RAD_W'(1) << FRAC_BITS;
    end else begin
      if (adv) begin
        vld <= {vld[L-2:0], ray.valid};
      end
      if (cfg.valid) begin
        min_dist <= cfg.min_hit_distance;
      end
    end
  end

  // stage 1: offsets from the sphere center
  logic signed [WDV-1:0] d1 [3];
  logic signed [31:0]    dir1 [3];
  logic [rsi_pkg::RAD_W-1:0] r1;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0]   <= WDV'(ray.origin_x) - WDV'(ray.center_x);
      d1[1]   <= WDV'(ray.origin_y) - WDV'(ray.center_y);
      d1[2]   <= WDV'(ray.origin_z) - WDV'(ray.center_z);
      dir1[0] <= ray.dir_x;
      dir1[1] <= ray.dir_y;
      dir1[2] <= ray.dir_z;
      r1      <= ray.radius;
    end
  end

  // stage 2: per-axis products
  logic signed [64:0] ph2 [3];
  logic signed [63:0] pa2 [3];
  logic signed [65:0] pc2 [3];
  logic [61:0]        rr2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ph2[i] <= 65'(dir1[i]) * 65'(d1[i]);
        pa2[i] <= 64'(dir1[i]) * 64'(dir1[i]);
        pc2[i] <= 66'(d1[i]) * 66'(d1[i]);
      end
      rr2 <= 62'(r1) * 62'(r1);
    end
  end

  // stage 3: dot products
  logic signed [WH-1:0] h3;
  logic [WA-1:0]        a3;
  logic signed [WC-1:0] c3;

  always_ff @(posedge clk) begin
    if (adv) begin
      h3 <= WH'(ph2[0]) + WH'(ph2[1]) + WH'(ph2[2]);
      a3 <= $unsigned(pa2[0]) + $unsigned(pa2[1]) + $unsigned(pa2[2]);
      c3 <= WC'(pc2[0]) + WC'(pc2[1]) + WC'(pc2[2]) - $signed(WC'(rr2));
    end
  end

  // stage 4: magnitudes for the wide multipliers
  logic signed [WH-1:0] h4;
  logic [WA-1:0]        a4;
  logic [WH-1:0]        habs4;
  logic [WC-1:0]        cabs4;
  logic                 cneg4;
  logic                 azero4;

  always_ff @(posedge clk) begin
    if (adv) begin
      h4     <= h3;
      a4     <= a3;
      habs4  <= h3[WH-1] ? $unsigned(-h3) : $unsigned(h3);
      cabs4  <= c3[WC-1] ? $unsigned(-c3) : $unsigned(c3);
      cneg4  <= c3[WC-1];
      azero4 <= (a3 == '0);
    end
  end

  logic [2*WH-1:0]   hsq;
  logic [WA+WC-1:0]  ac;

  rsi_mul #(.WA(WH), .WB(WH)) u_mul_hh (
    .clk(clk), .en(adv), .a(habs4), .b(habs4), .p(hsq)
  );

  rsi_mul #(.WA(WA), .WB(WC)) u_mul_ac (
    .clk(clk), .en(adv), .a(a4), .b(cabs4), .p(ac)
  );

  // side data travelling alongside the multipliers
  logic signed [WH-1:0] mh [3];
  logic [WA-1:0]        ma [3];
  logic                 mcneg [3];
  logic                 mazero [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      mh[0]     <= h4;
      ma[0]     <= a4;
      mcneg[0]  <= cneg4;
      mazero[0] <= azero4;
      for (int i = 1; i < 3; i++) begin
        mh[i]     <= mh[i-1];
        ma[i]     <= ma[i-1];
        mcneg[i]  <= mcneg[i-1];
        mazero[i] <= mazero[i-1];
      end
    end
  end

  // discriminant and square root pipeline; entry 0 holds the discriminant
  logic [WS-1:0]        sq_rem [0:NSQ];
  logic [WS-1:0]        sq_res [0:NSQ];
  logic signed [WH-1:0] sq_h [0:NSQ];
  logic [WA-1:0]        sq_a [0:NSQ];
  rsi_pkg::flags_t      sq_f [0:NSQ];
  logic [WS-1:0]        disc;

  assign disc = mcneg[2] ? WS'(hsq) + WS'(ac) : WS'(hsq) - WS'(ac);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0]     <= disc;
      sq_res[0]     <= '0;
      sq_h[0]       <= mh[2];
      sq_a[0]       <= ma[2];
      sq_f[0].azero <= mazero[2];
      sq_f[0].dneg  <= disc[WS-1];
      sq_f[0].dzero <= (disc == '0);
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [WS-1:0] SQ_BIT = WS'(1) << (2 * (NSQ - 1 - k));
    logic [WS-1:0] trial;

    // root bits never overlap the trial bit, so or stands for add
    assign trial = sq_res[k] | SQ_BIT;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq_rem[k] >= trial) begin
          sq_rem[k+1] <= sq_rem[k] - trial;
          sq_res[k+1] <= (sq_res[k] >> 1) | SQ_BIT;
        end else begin
          sq_rem[k+1] <= sq_rem[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
        sq_h[k+1] <= sq_h[k];
        sq_a[k+1] <= sq_a[k];
        sq_f[k+1] <= sq_f[k];
      end
    end
  end

  // numerator is -(h + root); work on its magnitude and sign
  logic [WN-1:0]   sum_a;
  logic [WA-1:0]   a_a;
  rsi_pkg::flags_t f_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_a <= WN'(sq_h[NSQ]) + WN'(sq_res[NSQ][NSQ-1:0]);
      a_a   <= sq_a[NSQ];
      f_a   <= sq_f[NSQ];
    end
  end

  logic [WN-1:0]   m_b;
  logic            neg_b;
  logic [WA-1:0]   a_b;
  logic [WA-1:0]   am1_b;
  rsi_pkg::flags_t f_b;
  logic            sum_pos;

  assign sum_pos = !sum_a[WN-1] && (sum_a != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_b <= sum_pos;
      m_b   <= sum_pos ? sum_a : -sum_a;
      a_b   <= a_a;
      am1_b <= a_a - WA'(1);
      f_b   <= f_a;
    end
  end

  // floor division of a negative numerator: divide magnitude + A - 1
  logic [WD-1:0]   m2_c;
  logic [WD-1:0]   lim_c;
  logic            neg_c;
  logic [WA-1:0]   a_c;
  rsi_pkg::flags_t f_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_c  <= (WD'(m_b) << FRAC_BITS) + (neg_b ? WD'(am1_b) : '0);
      lim_c <= (WD'(a_b) << 31) + (neg_b ? WD'(a_b) : '0);
      neg_c <= neg_b;
      a_c   <= a_b;
      f_c   <= f_b;
    end
  end

  // divider pipeline; entry 0 holds the saturation decision
  logic [WD-1:0]   dv_rem [0:NDV];
  logic [NDV-1:0]  dv_q   [0:NDV];
  logic [WA-1:0]   dv_a   [0:NDV];
  logic            dv_neg [0:NDV];
  logic            dv_sat [0:NDV];
  rsi_pkg::flags_t dv_f   [0:NDV];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= m2_c;
      dv_q[0]   <= '0;
      dv_a[0]   <= a_c;
      dv_neg[0] <= neg_c;
      dv_sat[0] <= (m2_c >= lim_c);
      dv_f[0]   <= f_c;
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_div
    logic [WD-1:0] trial;

    assign trial = WD'(dv_a[k]) << (NDV - 1 - k);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (dv_rem[k] >= trial) begin
          dv_rem[k+1] <= dv_rem[k] - trial;
          dv_q[k+1]   <= {dv_q[k][NDV-2:0], 1'b1};
        end else begin
          dv_rem[k+1] <= dv_rem[k];
          dv_q[k+1]   <= {dv_q[k][NDV-2:0], 1'b0};
        end
        dv_a[k+1]   <= dv_a[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_sat[k+1] <= dv_sat[k];
        dv_f[k+1]   <= dv_f[k];
      end
    end
  end

  // output register
  logic signed [31:0] tv;
  logic               ge;
  logic               hit_next;
  logic signed [31:0] dist_next;
  logic               tan_next;
  logic               o_hit;
  logic signed [31:0] o_dist;
  logic               o_tan;
  rsi_pkg::flags_t    fo;

  assign fo = dv_f[NDV];

  always_comb begin
    if (dv_sat[NDV]) begin
      tv = dv_neg[NDV] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      tv = dv_neg[NDV] ? $signed(-dv_q[NDV]) : $signed(dv_q[NDV]);
    end
    ge = tv >= $signed({1'b0, min_dist});
    if (fo.azero || fo.dneg) begin
      hit_next  = 1'b0;
      dist_next = '0;
      tan_next  = 1'b0;
    end else if (fo.dzero) begin
      hit_next  = 1'b1;
      dist_next = tv;
      tan_next  = 1'b1;
    end else begin
      hit_next  = ge;
      dist_next = ge ? tv : '0;
      tan_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_hit  <= hit_next;
      o_dist <= dist_next;
      o_tan  <= tan_next;
    end
  end

  assign result.valid        = vld[L-1];
  assign result.hit          = o_hit;
  assign result.hit_distance = o_dist;
  assign result.tangent      = o_tan;

endmodule

[sim/tb_ray_sphere_intersect.sv]
// tb_ray_sphere_intersect: self-checking regression for the ray/sphere hit test
// depends on rsi_pkg, rsi_ifs and the ray_sphere_intersect top level
// drives rays through a queue, predicts every result exactly and compares in order
module tb_ray_sphere_intersect;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [rsi_pkg::COORD_W-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
    logic [rsi_pkg::RAD_W-1:0] rad;
  } ray_t;

  typedef struct {
    logic hit;
    logic signed [rsi_pkg::COORD_W-1:0] hdist;
    logic tan;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rsi_ray_if ray_ch();
  rsi_hit_if res_ch();
  rsi_cfg_if cfg_ch();

  ray_sphere_intersect #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst), .ray(ray_ch), .result(res_ch), .cfg(cfg_ch)
  );

  always #4 clk = ~clk;

  ray_t rays_pending[$];
  hit_t hits_expected[$];
  logic [rsi_pkg::RAD_W-1:0] min_dist = 31'd65536;
  bit idle_on = 1'b1;
  int errors = 0;
  int long_hold_req = 0;
  int long_hold_seen = 0;
  int send_gap = 0;
  int recv_hold = 0;
  int cycles = 0;

  // exact solve of the reduced quadratic, smaller root, floor rounding
  function automatic hit_t solve_ray(ray_t r);
    wide_t d[3], v[3];
    wide_t h, a, c, disc, root, cand, num, q;
    hit_t e;
    logic signed [31:0] t;
    e = '{1'b0, 32'sd0, 1'b0};
    d[0] = wide_t'(r.ox) - wide_t'(r.cx);
    d[1] = wide_t'(r.oy) - wide_t'(r.cy);
    d[2] = wide_t'(r.oz) - wide_t'(r.cz);
    v[0] = wide_t'(r.dx);
    v[1] = wide_t'(r.dy);
    v[2] = wide_t'(r.dz);
    h = 0;
    a = 0;
    c = 0;
    for (int i = 0; i < 3; i++) begin
      h = h + v[i] * d[i];
      a = a + v[i] * v[i];
      c = c + d[i] * d[i];
    end
    c = c - wide_t'($signed({1'b0, r.rad})) * wide_t'($signed({1'b0, r.rad}));
    if (a == 0) return e;
    disc = h * h - a * c;
    if (disc < 0) return e;
    root = 0;
    if (disc != 0) begin
      for (int k = 67; k >= 0; k--) begin
        cand = root + (wide_t'(1) <<< k);
        if (cand * cand <= disc) root = cand;
      end
    end
    num = (-h - root) <<< FRAC;
    q = num / a;
    if (num < 0 && q * a != num) q = q - 1;
    if (q > 192'sd2147483647) t = 32'sh7fffffff;
    else if (q < -192'sd2147483648) t = 32'sh80000000;
    else t = q[31:0];
    if (disc == 0) begin
      e = '{1'b1, t, 1'b1};
    end else if (longint'(t) >= longint'({33'b0, min_dist})) begin
      e = '{1'b1, t, 1'b0};
    end
    return e;
  endfunction

  function automatic ray_t mk_ray(longint ox, longint oy, longint oz, longint dx,
                                  longint dy, longint dz, longint cx, longint cy,
                                  longint cz, longint rad);
    ray_t r;
    r.ox = ox[31:0]; r.oy = oy[31:0]; r.oz = oz[31:0];
    r.dx = dx[31:0]; r.dy = dy[31:0]; r.dz = dz[31:0];
    r.cx = cx[31:0]; r.cy = cy[31:0]; r.cz = cz[31:0];
    r.rad = rad[30:0];
    return r;
  endfunction

  function automatic longint srand(int bits);
    return longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (longint'(1) << bits);
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    longint ox, oy, oz, dx, dy, dz, k, m, rr;
    int mode;
    mode = $urandom_range(0, 9);
    ox = srand(21); oy = srand(21); oz = srand(21);
    dx = srand(18); dy = srand(18); dz = srand(18);
    case (mode)
      0, 1: begin
        r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      end
      8: begin
        // grazing sphere, discriminant exactly zero
        m = srand(20);
        rr = $urandom_range(1, 1 << 20);
        if (dx == 0) dx = 1;
        r = mk_ray(ox, oy, oz, dx, 0, 0, ox + m, oy + rr, oz, rr);
      end
      9: begin
        r = mk_ray(ox, oy, oz, 0, 0, 0, srand(21), srand(21), srand(21),
                   $urandom_range(0, 1 << 20));
      end
      default: begin
        // sphere centered near the ray, ahead or behind
        k = srand(4);
        r = mk_ray(ox, oy, oz, dx, dy, dz, ox + dx * k + srand(14), oy + dy * k + srand(14),
                   oz + dz * k + srand(14), $urandom_range(1 << 12, 1 << 20));
      end
    endcase
    return r;
  endfunction

  // sender: feeds queued rays and predicts each one as it is taken
  always @(posedge clk) begin
    ray_t r;
    bit taken;
    if (!rst) begin
      taken = ray_ch.valid && ray_ch.ready;
      if (taken) begin
        r.ox = ray_ch.origin_x; r.oy = ray_ch.origin_y; r.oz = ray_ch.origin_z;
        r.dx = ray_ch.dir_x; r.dy = ray_ch.dir_y; r.dz = ray_ch.dir_z;
        r.cx = ray_ch.center_x; r.cy = ray_ch.center_y; r.cz = ray_ch.center_z;
        r.rad = ray_ch.radius;
        hits_expected.push_back(solve_ray(r));
      end
      if (!ray_ch.valid || taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          ray_ch.valid <= 1'b0;
        end else if (rays_pending.size() > 0) begin
          r = rays_pending.pop_front();
          ray_ch.valid <= 1'b1;
          ray_ch.origin_x <= r.ox; ray_ch.origin_y <= r.oy; ray_ch.origin_z <= r.oz;
          ray_ch.dir_x <= r.dx; ray_ch.dir_y <= r.dy; ray_ch.dir_z <= r.dz;
          ray_ch.center_x <= r.cx; ray_ch.center_y <= r.cy; ray_ch.center_z <= r.cz;
          ray_ch.radius <= r.rad;
          if (idle_on && $urandom_range(0, 11) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          ray_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (long_hold_seen != long_hold_req) begin
        long_hold_seen <= long_hold_req;
        recv_hold <= 400;
        res_ch.ready <= 1'b0;
      end else if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        recv_hold <= $urandom_range(0, 16);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    hit_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (hits_expected.size() == 0) begin
        $display("%0t: result item with none expected, got hit %0b dist %0d tangent %0b",
                 $time, res_ch.hit, res_ch.hit_distance, res_ch.tangent);
        errors++;
      end else begin
        e = hits_expected.pop_front();
        if (res_ch.hit !== e.hit) begin
          $display("%0t: hit mismatch, expected %0b got %0b", $time, e.hit, res_ch.hit);
          errors++;
        end
        if (res_ch.hit_distance !== e.hdist) begin
          $display("%0t: hit_distance mismatch, expected %0d got %0d", $time, e.hdist,
                   res_ch.hit_distance);
          errors++;
        end
        if (res_ch.tangent !== e.tan) begin
          $display("%0t: tangent mismatch, expected %0b got %0b", $time, e.tan,
                   res_ch.tangent);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_sphere_intersect regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (rays_pending.size() > 0 || ray_ch.valid || hits_expected.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_dist(logic [rsi_pkg::RAD_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.min_hit_distance <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    min_dist = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) rays_pending.push_back(random_ray());
  endtask

  localparam longint ONE = 65536;
  localparam longint PMAX = 64'h7fffffff;
  localparam longint NMAX = -64'h80000000;

  initial begin
    ray_ch.valid = 1'b0;
    {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} = '0;
    {ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z} = '0;
    {ray_ch.center_x, ray_ch.center_y, ray_ch.center_z} = '0;
    ray_ch.radius = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.min_hit_distance = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rays with the reset minimum distance
    rays_pending.push_back(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rays_pending.push_back(mk_ray(5 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE));
    rays_pending.push_back(mk_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, ONE, 0, ONE));
    rays_pending.push_back(mk_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE));
    rays_pending.push_back(mk_ray(0, 0, 0, ONE, 0, 0, -5 * ONE, 0, 0, ONE));
    rays_pending.push_back(mk_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 2 * ONE));
    rays_pending.push_back(mk_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 3 * ONE, 0, ONE));
    rays_pending.push_back(mk_ray(0, 0, 0, 1, 0, 0, PMAX, 0, 0, ONE));
    rays_pending.push_back(mk_ray(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX,
                                  PMAX));
    rays_pending.push_back(mk_ray(NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, PMAX, PMAX, PMAX,
                                  PMAX));
    rays_pending.push_back(mk_ray(PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, NMAX, PMAX, NMAX, 0));
    rays_pending.push_back(mk_ray(NMAX, 0, 0, PMAX, 0, 0, PMAX, 0, 0, PMAX));
    rays_pending.push_back(mk_ray(0, 0, 0, NMAX, NMAX, NMAX, 0, 0, 0, PMAX));
    rays_pending.push_back(mk_ray(0, 0, 0, -1, -1, -1, PMAX, PMAX, PMAX, 1));
    rays_pending.push_back(mk_ray(0, 0, 0, 1, 1, 1, 0, 0, 0, 0));
    rays_pending.push_back(mk_ray(-1, -1, -1, 1, 0, 0, NMAX, -1, -1, PMAX));
    wait_drained();

    write_min_dist(31'd0);
    add_random(250);
    wait_drained();

    write_min_dist(31'h7fffffff);
    long_hold_req = long_hold_req + 1;
    add_random(300);
    wait_drained();

    write_min_dist(31'($urandom_range(0, 8 * ONE)));
    add_random(250);
    wait_drained();

    write_min_dist(31'd65536);
    idle_on = 1'b0;
    add_random(300);
    wait_drained();

    if (errors == 0 && hits_expected.size() == 0) begin
      $display("ray_sphere_intersect regression: pass");
    end else begin
      $display("ray_sphere_intersect regression: fail");
    end
    $finish;
  end

endmodule
